### hdl/scba_pkg.sv
// Shared types and constants of the size-class bitmap slot allocator.
// No dependencies; every other file in hdl/ but scba_ram uses this package by scoped names.
`default_nettype none

package scba_pkg;

    localparam int CLS_W       = 5;
    localparam int ARENA_OUT_W = 2;
    localparam int SLOT_OUT_W  = 9;
    localparam int OFF_W       = 29;
    localparam int SIZE_W      = 32;
    localparam int SLOT_MAX_W  = 12;   // holds any slot below 4096
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = 6;
    localparam int MIN_SHIFT   = 4;    // smallest class is 16 bytes
    localparam int LARGE_LOG2  = 20;   // requests above 1 MiB are handed off

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_FREED     = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_ZERO      = 3'd3,
        ST_LARGE     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_ALLOC,
        KIND_FREE
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        status_t                status;
        logic [CLS_W-1:0]       cls;
        logic [ARENA_OUT_W-1:0] arena;
        logic [SLOT_MAX_W-1:0]  slot;
        logic [OFF_W-1:0]       offset;
    } req_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN_RD,
        FSM_SCAN_CHK,
        FSM_FREE_RD,
        FSM_FREE_WR,
        FSM_DONE
    } fsm_t;

endpackage

`default_nettype wire

### hdl/scba_ram.sv
// Single-port-write, single-port-read bitmap memory with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module scba_ram #(
    parameter int DEPTH = 544,
    parameter int WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/scba_decode.sv
// Request decoder: size class lookup for allocates, range checks for frees.
// Depends on scba_pkg.
`default_nettype none

module scba_decode #(
    parameter int NUM_CLASSES      = 17,
    parameter int ARENAS_PER_CLASS = 4,
    parameter int SLOTS_PER_ARENA  = 512
) (
    input  wire logic                               operation,
    input  wire logic [scba_pkg::SIZE_W-1:0]        request_size,
    input  wire logic [scba_pkg::CLS_W-1:0]         free_class,
    input  wire logic [scba_pkg::ARENA_OUT_W-1:0]   free_arena,
    input  wire logic [scba_pkg::OFF_W-1:0]         free_offset,
    output scba_pkg::req_t                          req
);

    localparam int SZ_W = scba_pkg::LARGE_LOG2 + 1;

    logic [SZ_W-1:0]             size_m1;
    logic [scba_pkg::CLS_W-1:0]  ceil_log2;
    logic [scba_pkg::CLS_W-1:0]  alloc_cls;
    logic [scba_pkg::CLS_W:0]    shamt;
    logic [scba_pkg::OFF_W-1:0]  low_mask;
    logic [scba_pkg::OFF_W-1:0]  slot_wide;
    logic                        free_ok;

    always_comb
    begin
        // ceil(log2(size)) from the top set bit of size - 1
        size_m1   = SZ_W'(request_size - 32'd1);
        ceil_log2 = '0;
        for (int i = 0; i < SZ_W; i++)
        begin
            if (size_m1[i])
            begin
                ceil_log2 = scba_pkg::CLS_W'(i + 1);
            end
        end
        alloc_cls = (ceil_log2 > scba_pkg::CLS_W'(scba_pkg::MIN_SHIFT))
                  ? ceil_log2 - scba_pkg::CLS_W'(scba_pkg::MIN_SHIFT) : '0;

        shamt     = {1'b0, free_class} + (scba_pkg::CLS_W + 1)'(scba_pkg::MIN_SHIFT);
        low_mask  = ~({scba_pkg::OFF_W{1'b1}} << shamt);
        slot_wide = free_offset >> shamt;
        free_ok   = (32'(free_class) < NUM_CLASSES)
                 && (32'(free_arena) < ARENAS_PER_CLASS)
                 && ((free_offset & low_mask) == '0)
                 && (32'(slot_wide) < SLOTS_PER_ARENA);

        req = '0;
        if (operation == scba_pkg::OP_FREE)
        begin
            if (free_ok)
            begin
                req.kind   = scba_pkg::KIND_FREE;
                req.status = scba_pkg::ST_FREED;
                req.cls    = free_class;
                req.arena  = free_arena;
                req.slot   = scba_pkg::SLOT_MAX_W'(slot_wide);
                req.offset = free_offset;
            end
            else
            begin
                req.kind   = scba_pkg::KIND_DONE;
                req.status = scba_pkg::ST_IGNORED;
            end
        end
        else if (request_size == '0)
        begin
            req.kind   = scba_pkg::KIND_DONE;
            req.status = scba_pkg::ST_ZERO;
        end
        else if (request_size > (32'd1 << scba_pkg::LARGE_LOG2)
              || 32'(alloc_cls) >= NUM_CLASSES)
        begin
            req.kind   = scba_pkg::KIND_DONE;
            req.status = scba_pkg::ST_LARGE;
        end
        else
        begin
            req.kind   = scba_pkg::KIND_ALLOC;
            req.status = scba_pkg::ST_ALLOCATED;
            req.cls    = alloc_cls;
        end
    end

endmodule

`default_nettype wire

### hdl/size_class_bitmap_slot_allocator_unit.sv
// Top level of the size-class bitmap slot allocator: control FSM and bitmap scan.
// Depends on scba_pkg, scba_decode and scba_ram.
//
// One item at a time goes through the block. After reset the bitmap memory is
// swept clean, one 64-bit word per cycle, across all NUM_CLASSES *
// ARENAS_PER_CLASS * ceil(SLOTS_PER_ARENA / 64) words (544 at the defaults);
// req_stall stays high during that sweep. A zero-size, large or rejected free
// item goes straight to the done state. A valid free reads, clears and writes
// back one bitmap word. An allocate walks the words of its class in arena
// order, a read and a check per word on the single memory read port, and stops
// at the first word with a free slot, or after the last word of the last arena
// when the class is full. A finished result waits in an output register, so
// the next item is accepted while the result is still stalled; a second result
// waits until the first is taken.
`default_nettype none

module size_class_bitmap_slot_allocator_unit #(
    parameter int NUM_CLASSES      = 17,
    parameter int ARENAS_PER_CLASS = 4,
    parameter int SLOTS_PER_ARENA  = 512
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic                                operation,
    input  wire logic [scba_pkg::SIZE_W-1:0]         request_size,
    input  wire logic [scba_pkg::CLS_W-1:0]          free_class,
    input  wire logic [scba_pkg::ARENA_OUT_W-1:0]    free_arena,
    input  wire logic [scba_pkg::OFF_W-1:0]          free_offset,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic [2:0]                               status,
    output logic [scba_pkg::CLS_W-1:0]               class_index,
    output logic [scba_pkg::ARENA_OUT_W-1:0]         arena_index,
    output logic [scba_pkg::SLOT_OUT_W-1:0]          slot_index,
    output logic [scba_pkg::OFF_W-1:0]               byte_offset
);

    localparam int WORDS     = (SLOTS_PER_ARENA + scba_pkg::WORD_BITS - 1)
                             / scba_pkg::WORD_BITS;
    localparam int DEPTH     = NUM_CLASSES * ARENAS_PER_CLASS * WORDS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ARENA_W   = (ARENAS_PER_CLASS > 1) ? $clog2(ARENAS_PER_CLASS) : 1;
    localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LAST_BITS = SLOTS_PER_ARENA - (WORDS - 1) * scba_pkg::WORD_BITS;

    // Bits beyond the last slot of an arena read as used so the scan skips them
    localparam logic [scba_pkg::WORD_BITS-1:0] PAD_MASK =
        ~((64'd1 << LAST_BITS) - 64'd1);

    scba_pkg::fsm_t   state_reg, state_next;
    scba_pkg::req_t   req_reg, req_next;
    scba_pkg::req_t   dec_req;
    logic [ARENA_W-1:0] arena_reg, arena_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;

    logic                              rsp_valid_reg, rsp_valid_next;
    scba_pkg::status_t                 status_reg;
    logic [scba_pkg::CLS_W-1:0]        class_reg;
    logic [scba_pkg::ARENA_OUT_W-1:0]  arena_out_reg;
    logic [scba_pkg::SLOT_OUT_W-1:0]   slot_reg;
    logic [scba_pkg::OFF_W-1:0]        offset_reg;
    logic                              rsp_load;

    logic                              mem_we, mem_re;
    logic [ADDR_W-1:0]                 mem_waddr, mem_raddr, word_addr, free_addr;
    logic [scba_pkg::WORD_BITS-1:0]    mem_wdata, mem_rdata, seen;
    logic [scba_pkg::BIT_W-1:0]        hit_bit;
    logic                              hit;
    logic [scba_pkg::SLOT_MAX_W-1:0]   hit_slot;

    scba_decode #(
        .NUM_CLASSES      (NUM_CLASSES),
        .ARENAS_PER_CLASS (ARENAS_PER_CLASS),
        .SLOTS_PER_ARENA  (SLOTS_PER_ARENA)
    ) u_decode (
        .operation    (operation),
        .request_size (request_size),
        .free_class   (free_class),
        .free_arena   (free_arena),
        .free_offset  (free_offset),
        .req          (dec_req)
    );

    scba_ram #(
        .DEPTH (DEPTH),
        .WIDTH (scba_pkg::WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Word addresses: (class * arenas + arena) * words + word
    assign word_addr = (ADDR_W'(req_reg.cls) * ADDR_W'(ARENAS_PER_CLASS)
                      + ADDR_W'(arena_reg)) * ADDR_W'(WORDS) + ADDR_W'(word_reg);
    assign free_addr = (ADDR_W'(req_reg.cls) * ADDR_W'(ARENAS_PER_CLASS)
                      + ADDR_W'(req_reg.arena)) * ADDR_W'(WORDS)
                      + ADDR_W'(req_reg.slot >> scba_pkg::BIT_W);

    // Lowest clear bit of the word just read
    always_comb
    begin
        seen = mem_rdata;
        if (32'(word_reg) == WORDS - 1)
        begin
            seen = mem_rdata | PAD_MASK;
        end
        hit     = ~(&seen);
        hit_bit = '0;
        for (int i = scba_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!seen[i])
            begin
                hit_bit = scba_pkg::BIT_W'(i);
            end
        end
        hit_slot = (scba_pkg::SLOT_MAX_W'(word_reg) << scba_pkg::BIT_W)
                 | scba_pkg::SLOT_MAX_W'(hit_bit);
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        arena_next     = arena_reg;
        word_next      = word_reg;
        clr_next       = clr_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_addr;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = word_addr;
        req_stall      = 1'b1;
        rsp_load       = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        unique case (state_reg)
            scba_pkg::FSM_CLEAR:
            begin
                // Sweep the memory to zero, one word a cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    state_next = scba_pkg::FSM_IDLE;
                end
            end
            scba_pkg::FSM_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    req_next   = dec_req;
                    arena_next = '0;
                    word_next  = '0;
                    unique case (dec_req.kind)
                        scba_pkg::KIND_ALLOC: state_next = scba_pkg::FSM_SCAN_RD;
                        scba_pkg::KIND_FREE:  state_next = scba_pkg::FSM_FREE_RD;
                        default:              state_next = scba_pkg::FSM_DONE;
                    endcase
                end
            end
            scba_pkg::FSM_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = scba_pkg::FSM_SCAN_CHK;
            end
            scba_pkg::FSM_SCAN_CHK:
            begin
                if (hit)
                begin
                    // Claim the slot and build the result
                    mem_we       = 1'b1;
                    mem_wdata    = mem_rdata | (64'd1 << hit_bit);
                    req_next.arena  = scba_pkg::ARENA_OUT_W'(arena_reg);
                    req_next.slot   = hit_slot;
                    req_next.offset = scba_pkg::OFF_W'(
                        {{(scba_pkg::OFF_W - scba_pkg::SLOT_MAX_W){1'b0}}, hit_slot}
                        << (req_reg.cls + scba_pkg::CLS_W'(scba_pkg::MIN_SHIFT)));
                    state_next   = scba_pkg::FSM_DONE;
                end
                else if (32'(word_reg) != WORDS - 1)
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = scba_pkg::FSM_SCAN_RD;
                end
                else if (32'(arena_reg) != ARENAS_PER_CLASS - 1)
                begin
                    word_next  = '0;
                    arena_next = arena_reg + 1'b1;
                    state_next = scba_pkg::FSM_SCAN_RD;
                end
                else
                begin
                    req_next.status = scba_pkg::ST_FULL;
                    state_next      = scba_pkg::FSM_DONE;
                end
            end
            scba_pkg::FSM_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = free_addr;
                state_next = scba_pkg::FSM_FREE_WR;
            end
            scba_pkg::FSM_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = free_addr;
                mem_wdata  = mem_rdata
                           & ~(64'd1 << req_reg.slot[scba_pkg::BIT_W-1:0]);
                state_next = scba_pkg::FSM_DONE;
            end
            scba_pkg::FSM_DONE:
            begin
                // Hand the result over once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = scba_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scba_pkg::FSM_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        arena_reg <= arena_next;
        word_reg  <= word_next;
        if (rsp_load)
        begin
            status_reg    <= req_reg.status;
            class_reg     <= req_reg.cls;
            arena_out_reg <= req_reg.arena;
            slot_reg      <= scba_pkg::SLOT_OUT_W'(req_reg.slot);
            offset_reg    <= req_reg.offset;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign class_index = class_reg;
    assign arena_index = arena_out_reg;
    assign slot_index  = slot_reg;
    assign byte_offset = offset_reg;

endmodule

`default_nettype wire

### hdl/scba_checker.sv
// Port-level checks of the slot allocator result channel, bound to the top level.
// Depends on scba_pkg and size_class_bitmap_slot_allocator_unit.
`default_nettype none

module scba_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [2:0]  status,
    input wire logic [4:0]  class_index,
    input wire logic [1:0]  arena_index,
    input wire logic [8:0]  slot_index,
    input wire logic [28:0] byte_offset
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
        else $error("result dropped while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == scba_pkg::ST_ZERO || status == scba_pkg::ST_LARGE
                      || status == scba_pkg::ST_IGNORED)
        |-> class_index == '0 && arena_index == '0 && slot_index == '0
            && byte_offset == '0)
        else $error("rejected item carries nonzero fields");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == scba_pkg::ST_FULL
        |-> arena_index == '0 && slot_index == '0 && byte_offset == '0)
        else $error("full class result carries a slot");

    a_free_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == scba_pkg::ST_FREED
        |-> (byte_offset & ~({29{1'b1}} << (class_index + 5'd4))) == '0)
        else $error("freed offset not aligned to its class");

endmodule

bind size_class_bitmap_slot_allocator_unit scba_checker u_scba_checker (.*);

`default_nettype wire
